// ===== design/qte_pkg.sv =====
// shared types, constants and the arctangent table for the quaternion to euler block
// no dependencies
`default_nettype none
package qte_pkg;

    localparam int SUM_W     = 34;   // doubled product sums, q4.28 with growth
    localparam int SP_W      = 29;   // unclamped sine term fits here
    localparam int CW        = 46;   // cordic datapath width
    localparam int ACC_W     = 32;   // binary angle accumulator, full turn = 2^32
    localparam int ATAN_LEN  = 24;
    localparam int SQ_STAGES = 29;   // one stage per result bit of a 29 bit root of a 57 bit radicand
    localparam int QDEPTH    = 4;
    localparam int QCNT_W    = 3;
    localparam int QPTR_W    = 2;

    localparam logic signed [SUM_W-1:0] ONE_Q28 = SUM_W'(64'sd268435456);
    localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ROUND_HALF = 32'h0000_8000;
    localparam logic signed [15:0] QUARTER_POS = 16'sd16384;
    localparam logic signed [15:0] QUARTER_NEG = -16'sd16384;

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SP_W-1:0]  sp;
        logic                    clamp;
        logic                    clamp_pos;
    } t_front_item;

    typedef struct packed {
        logic v1;
        logic v2;
    } t_front_stat;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_fifo_stat;

    function automatic logic [ACC_W-1:0] atan_entry(input int idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/quaternion_to_euler_angles.sv =====
// top level: quaternion to z-y-x euler angles, stream in and stream out
// depends on qte_pkg, qte_front, qte_fifo, qte_back
//
// usage:
//   the slave channel takes one quaternion item per accepted beat, tdata holds
//   w, x, y, z as signed q2.14 from the lowest bit up. the master channel gives
//   one item per quaternion: tdata holds roll, pitch, yaw as signed binary
//   angles (32768 = pi), tuser holds the pitch clamp flag.
//   throughput is one item per cycle while the master side keeps taking items.
//   the path runs through two front stages of products and sums, a
//   queue write, a square stage, a remainder stage, a square root load stage
//   and 29 square root stages, a cordic setup stage, one cordic stage per
//   iteration and the output register. the square root pipeline is the longest part.
//   the front runs freely and the input ready comes from queue credit: an
//   item is taken while queue entries plus items in the front stay below the
//   queue depth of four. the back pipeline advances while the output register
//   is empty or being taken, so a stall on the master side freezes the back,
//   fills the queue and then drops the slave ready; no item is lost.
//   synchronous reset empties the front, queue, back and output register;
//   nothing else is kept, there is no clearing pass.
`default_nettype none
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [47:0] o_m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
    output      logic [0:0]  o_m_axis_tuser    // pitch_clamped
);

    t_front_stat front_stat;
    logic        front_valid;
    t_front_item front_item;
    t_front_item q_item;
    t_fifo_stat  q_stat;
    logic        q_pop;
    logic        in_acc;
    logic [QCNT_W:0] busy;
    logic signed [15:0] roll, pitch, yaw;
    logic        clamped;

    // credit: queue fill plus items still in the two front stages
    assign busy = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(front_stat.v1)
                + (QCNT_W+1)'(front_stat.v2);
    assign o_s_axis_tready = (busy < (QCNT_W+1)'(QDEPTH));
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .i_w     (i_s_axis_tdata[15:0]),
        .i_x     (i_s_axis_tdata[31:16]),
        .i_y     (i_s_axis_tdata[47:32]),
        .i_z     (i_s_axis_tdata[63:48]),
        .o_stat  (front_stat),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    qte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_stat  (q_stat)
    );

    qte_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!q_stat.empty),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .i_ready   (i_m_axis_tready),
        .o_valid   (o_m_axis_tvalid),
        .o_roll    (roll),
        .o_pitch   (pitch),
        .o_yaw     (yaw),
        .o_clamped (clamped)
    );

    assign o_m_axis_tdata = {yaw, pitch, roll};
    assign o_m_axis_tuser = clamped;

    // the credit scheme must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && !q_pop) |-> !q_stat.full)
        else $error("queue overflow");

    // pops only come from a queue that holds an item
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue underflow");

    // accepted items and queue content stay within the credit budget
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (q_stat.count <= QCNT_W'(QDEPTH)))
        else $error("credit exceeded");

endmodule
`default_nettype wire

// ===== design/qte_front.sv =====
// front part: quaternion products and doubled sums, pitch clamp classification
// depends on qte_pkg
`default_nettype none
module qte_front
    import qte_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_w,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_z,
    output      t_front_stat        o_stat,
    output      logic               o_valid,
    output      t_front_item        o_item
);

    logic               r_v1;
    logic               r_v2;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_front_item        r_item;
    t_front_item        n_item;
    logic signed [SUM_W-1:0] sp_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wx <= i_w * i_x;
        r_yz <= i_y * i_z;
        r_xx <= i_x * i_x;
        r_yy <= i_y * i_y;
        r_wy <= i_w * i_y;
        r_zx <= i_z * i_x;
        r_wz <= i_w * i_z;
        r_xy <= i_x * i_y;
        r_zz <= i_z * i_z;
        r_item <= n_item;
    end

    always_comb begin
        n_item.sr = (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
        n_item.cr = ONE_Q28 - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        sp_full   = (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
        n_item.sy = (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        n_item.cy = ONE_Q28 - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
        n_item.sp = sp_full[SP_W-1:0];
        n_item.clamp_pos = (sp_full >= ONE_Q28);
        n_item.clamp = (sp_full >= ONE_Q28) || (sp_full <= -ONE_Q28);
    end

    assign o_stat.v1 = r_v1;
    assign o_stat.v2 = r_v2;
    assign o_valid   = r_v2;
    assign o_item    = r_item;

endmodule
`default_nettype wire

// ===== design/qte_fifo.sv =====
// short queue between front and back parts
// depends on qte_pkg
`default_nettype none
module qte_fifo
    import qte_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire t_front_item  i_data,
    input  wire logic         i_pop,
    output t_front_item o_data,
    output t_fifo_stat o_stat
);

    t_front_item       r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));

endmodule
`default_nettype wire

// ===== design/qte_sqrt.sv =====
// pipelined integer square root, one result bit per stage, with side payload
// depends on qte_pkg
`default_nettype none
module qte_sqrt
    import qte_pkg::*;
#(
    parameter int PW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [56:0]   i_rem,
    input  wire logic [PW-1:0] i_pay,
    output      logic          o_valid,
    output      logic [28:0]   o_root,
    output      logic [PW-1:0] o_pay
);

    logic [SQ_STAGES:0] r_valid;
    logic [57:0]        r_n   [0:SQ_STAGES];
    logic [57:0]        r_res [0:SQ_STAGES];
    logic [PW-1:0]      r_pay [0:SQ_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= '0;
        else if (i_en) r_valid <= {r_valid[SQ_STAGES-1:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        logic [57:0] b;
        logic [57:0] t;
        if (i_en) begin
            r_n[0]   <= {1'b0, i_rem};
            r_res[0] <= '0;
            r_pay[0] <= i_pay;
            for (int k = 0; k < SQ_STAGES; k++) begin
                b = 58'(1) << (56 - 2 * k);
                t = r_res[k] + b;
                if (r_n[k] >= t) begin
                    r_n[k+1]   <= r_n[k] - t;
                    r_res[k+1] <= (r_res[k] >> 1) + b;
                end else begin
                    r_n[k+1]   <= r_n[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
                r_pay[k+1] <= r_pay[k];
            end
        end
    end

    assign o_valid = r_valid[SQ_STAGES];
    assign o_root  = r_res[SQ_STAGES][28:0];
    assign o_pay   = r_pay[SQ_STAGES];

endmodule
`default_nettype wire

// ===== design/qte_cordic.sv =====
// three lane pipelined vectoring cordic, one iteration per stage
// depends on qte_pkg
`default_nettype none
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [SUM_W-1:0] i_y [0:2],
    input  wire logic signed [SUM_W-1:0] i_x [0:2],
    input  wire logic [1:0]             i_tag,
    output      logic                   o_valid,
    output      logic [ACC_W-1:0]       o_acc [0:2],
    output      logic [1:0]             o_tag
);

    localparam int N = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

    logic [N:0]              r_valid;
    logic signed [CW-1:0]    r_x    [0:N][0:2];
    logic signed [CW-1:0]    r_y    [0:N][0:2];
    logic [ACC_W-1:0]        r_acc  [0:N][0:2];
    logic                    r_skip [0:N][0:2];
    logic [1:0]              r_tag  [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= '0;
        else if (i_en) r_valid <= {r_valid[N-1:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] xe;
        logic signed [CW-1:0] ye;
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int l = 0; l < 3; l++) begin
                xe = CW'(i_x[l]) <<< 8;
                ye = CW'(i_y[l]) <<< 8;
                if (i_y[l] == '0) begin
                    // zero sine operand: angle is known, no iterations
                    r_skip[0][l] <= 1'b1;
                    r_acc[0][l]  <= (i_x[l] < 0) ? HALF_TURN : '0;
                    r_x[0][l]    <= xe;
                    r_y[0][l]    <= ye;
                end else if (i_x[l] < 0) begin
                    r_skip[0][l] <= 1'b0;
                    r_acc[0][l]  <= HALF_TURN;
                    r_x[0][l]    <= -xe;
                    r_y[0][l]    <= -ye;
                end else begin
                    r_skip[0][l] <= 1'b0;
                    r_acc[0][l]  <= '0;
                    r_x[0][l]    <= xe;
                    r_y[0][l]    <= ye;
                end
            end
            for (int k = 0; k < N; k++) begin
                r_tag[k+1] <= r_tag[k];
                for (int l = 0; l < 3; l++) begin
                    r_skip[k+1][l] <= r_skip[k][l];
                    if (r_skip[k][l]) begin
                        r_x[k+1][l]   <= r_x[k][l];
                        r_y[k+1][l]   <= r_y[k][l];
                        r_acc[k+1][l] <= r_acc[k][l];
                    end else if (r_y[k][l] > 0) begin
                        r_x[k+1][l]   <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l]   <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_acc[k+1][l] <= r_acc[k][l] + atan_entry(k);
                    end else begin
                        r_x[k+1][l]   <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l]   <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_acc[k+1][l] <= r_acc[k][l] - atan_entry(k);
                    end
                end
            end
        end
    end

    assign o_valid = r_valid[N];
    assign o_tag   = r_tag[N];
    assign o_acc   = r_acc[N];

endmodule
`default_nettype wire

// ===== design/qte_back.sv =====
// back part: pitch cosine by square root, three arctangents, output register
// depends on qte_pkg, qte_sqrt, qte_cordic
`default_nettype none
module qte_back
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_front_item i_item,
    output logic             o_pop,
    input  wire logic        i_ready,
    output logic             o_valid,
    output logic signed [15:0] o_roll,
    output logic signed [15:0] o_pitch,
    output logic signed [15:0] o_yaw,
    output logic             o_clamped
);

    localparam int PW = $bits(t_front_item);

    logic        en;
    logic        r_a_valid;
    t_front_item r_a_item;
    logic [56:0] r_a_sq;
    logic        r_b_valid;
    t_front_item r_b_item;
    logic [56:0] r_b_rem;

    logic        sq_valid;
    logic [28:0] sq_root;
    t_front_item sq_item;
    logic [PW-1:0] sq_pay;

    logic signed [SUM_W-1:0] c_y [0:2];
    logic signed [SUM_W-1:0] c_x [0:2];
    logic             c_valid;
    logic [ACC_W-1:0] c_acc [0:2];
    logic [1:0]       c_tag;
    logic [ACC_W-1:0] rnd [0:2];

    logic              r_valid;
    logic signed [15:0] r_roll, r_pitch, r_yaw;
    logic              r_clamped;

    assign en    = !r_valid || i_ready;
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item <= i_item;
            r_a_sq   <= 57'(i_item.sp * i_item.sp);
            r_b_item <= r_a_item;
            r_b_rem  <= (57'(1) << 56) - r_a_sq;
        end
    end

    qte_sqrt #(
        .PW(PW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_rem   (r_b_rem),
        .i_pay   (r_b_item),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    assign sq_item = t_front_item'(sq_pay);

    always_comb begin
        c_y[0] = sq_item.sr;
        c_x[0] = sq_item.cr;
        c_y[1] = SUM_W'(sq_item.sp);
        c_x[1] = SUM_W'({1'b0, sq_root});
        c_y[2] = sq_item.sy;
        c_x[2] = sq_item.cy;
    end

    qte_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_y     (c_y),
        .i_x     (c_x),
        .i_tag   ({sq_item.clamp, sq_item.clamp_pos}),
        .o_valid (c_valid),
        .o_acc   (c_acc),
        .o_tag   (c_tag)
    );

    always_comb begin
        for (int l = 0; l < 3; l++) rnd[l] = c_acc[l] + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (en) r_valid <= c_valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll    <= rnd[0][31:16];
            r_yaw     <= rnd[2][31:16];
            r_clamped <= c_tag[1];
            if (c_tag[1]) r_pitch <= c_tag[0] ? QUARTER_POS : QUARTER_NEG;
            else          r_pitch <= rnd[1][31:16];
        end
    end

    assign o_valid   = r_valid;
    assign o_roll    = r_roll;
    assign o_pitch   = r_pitch;
    assign o_yaw     = r_yaw;
    assign o_clamped = r_clamped;

endmodule
`default_nettype wire
